@@ hdl/fbce_pkg.sv @@
// ----------------------------------------------------------------------------
// fbce_pkg
// Shared types, codes and constants of the 4-bit CPU execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fbce_pkg;

  localparam int STACK_DEPTH_DEF = 4;
  localparam int INDEX_REG_COUNT = 16;
  localparam int QUEUE_DEPTH     = 2;

  // memory / port request codes
  localparam logic [3:0] MEM_NONE       = 4'd0;
  localparam logic [3:0] MEM_ROM_READ   = 4'd1;
  localparam logic [3:0] MEM_CHAR_READ  = 4'd2;
  localparam logic [3:0] MEM_STAT_READ  = 4'd3;
  localparam logic [3:0] MEM_CHAR_WRITE = 4'd4;
  localparam logic [3:0] MEM_STAT_WRITE = 4'd5;
  localparam logic [3:0] MEM_RAM_OUT    = 4'd6;
  localparam logic [3:0] MEM_ROM_OUT    = 4'd7;
  localparam logic [3:0] MEM_ROM_IN     = 4'd8;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_INVALID   = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd3;
  localparam logic [2:0] ERR_UNSUPP    = 3'd4;

  // opcode nibbles
  localparam logic [3:0] OPR_NOP = 4'h0;
  localparam logic [3:0] OPR_JCN = 4'h1;
  localparam logic [3:0] OPR_FIM = 4'h2;
  localparam logic [3:0] OPR_FIN = 4'h3;
  localparam logic [3:0] OPR_JUN = 4'h4;
  localparam logic [3:0] OPR_JMS = 4'h5;
  localparam logic [3:0] OPR_INC = 4'h6;
  localparam logic [3:0] OPR_ISZ = 4'h7;
  localparam logic [3:0] OPR_ADD = 4'h8;
  localparam logic [3:0] OPR_SUB = 4'h9;
  localparam logic [3:0] OPR_LD  = 4'hA;
  localparam logic [3:0] OPR_XCH = 4'hB;
  localparam logic [3:0] OPR_BBL = 4'hC;
  localparam logic [3:0] OPR_LDM = 4'hD;
  localparam logic [3:0] OPR_IO  = 4'hE;
  localparam logic [3:0] OPR_ACC = 4'hF;

  // decoded instruction handed from front to back
  typedef struct packed {
    logic [3:0] opr;
    logic [3:0] opa;
    logic [7:0] b2;
    logic       test;
    logic [7:0] rd;
    logic       two;
    logic       invalid;
  } fbce_instr_t;

endpackage
`default_nettype wire

@@ hdl/four_bit_cpu_execute_unit.sv @@
// ----------------------------------------------------------------------------
// four_bit_cpu_execute_unit
// Execute core of a 4-bit microprocessor: one instruction in, one result out.
// ----------------------------------------------------------------------------
// Input channel: drive instr_byte1/2, test_level and read_data with push;
// the request is taken when push is high and full is low.
// Output channel: while empty is low the oldest result (next_pc, acc_value,
// carry_flag, memory request, error_code) is on the ports; pop takes it.
// A two-entry queue separates the decode front from the execute back, and
// the back keeps one registered result.
// A taken request is written to a queue slot and then to the result register
// before it is visible on the ports.
// Throughput: one instruction per cycle while results are popped; the execute
// stage finishes a whole instruction, including state writeback, as its result is registered.
// Reset clears the queue, the result valid flag, accumulator, carry, index
// registers, PC stack and chip selection.
// When pop stays low the result holds, the back stops, the queue fills and
// full rises after two more requests.
// ----------------------------------------------------------------------------
`default_nettype none
module four_bit_cpu_execute_unit
  import fbce_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  instr_byte1,
  input  wire logic [7:0]  instr_byte2,
  input  wire logic        test_level,
  input  wire logic [7:0]  read_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [11:0]      next_pc,
  output logic [3:0]       acc_value,
  output logic             carry_flag,
  output logic [3:0]       mem_op,
  output logic [3:0]       mem_chip,
  output logic [7:0]       mem_addr,
  output logic [3:0]       write_data,
  output logic [2:0]       error_code
);

  logic        q_valid, q_take;
  fbce_instr_t q_data;

  fbce_front u_front (
    .clk, .rst, .push, .full, .instr_byte1, .instr_byte2, .test_level,
    .read_data, .q_valid, .q_data, .q_take
  );

  fbce_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_take, .empty, .pop, .next_pc,
    .acc_value, .carry_flag, .mem_op, .mem_chip, .mem_addr, .write_data,
    .error_code
  );

endmodule
`default_nettype wire

@@ hdl/fbce_front.sv @@
// ----------------------------------------------------------------------------
// fbce_front
// Accepts instructions, classifies length and validity, and queues them.
// ----------------------------------------------------------------------------
`default_nettype none
module fbce_front
  import fbce_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  instr_byte1,
  input  wire logic [7:0]  instr_byte2,
  input  wire logic        test_level,
  input  wire logic [7:0]  read_data,
  output logic             q_valid,
  output fbce_instr_t      q_data,
  input  wire logic        q_take
);

  fbce_instr_t dec;
  fbce_instr_t slot [QUEUE_DEPTH];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  count;
  logic        do_push;

  // classify
  always_comb begin
    dec.opr  = instr_byte1[7:4];
    dec.opa  = instr_byte1[3:0];
    dec.b2   = instr_byte2;
    dec.test = test_level;
    dec.rd   = read_data;
    dec.two  = (dec.opr == OPR_JCN) || (dec.opr == OPR_JUN) || (dec.opr == OPR_JMS) ||
               (dec.opr == OPR_ISZ) || (dec.opr == OPR_FIM && !dec.opa[0]);
    dec.invalid = 1'b0;
    case (dec.opr)
      OPR_NOP: dec.invalid = (dec.opa != 4'd0);
      OPR_JCN: dec.invalid = !(dec.opa inside {4'd1, 4'd2, 4'd4, 4'd9, 4'd10, 4'd12});
      OPR_ACC: dec.invalid = (dec.opa inside {4'd14, 4'd15});
      default: dec.invalid = 1'b0;
    endcase
  end

  assign full    = (count == 2'(QUEUE_DEPTH));
  assign q_valid = (count != 2'd0);
  assign q_data  = slot[rd_ptr];
  assign do_push = push && !full;

  // two-entry queue
  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= dec;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (q_take) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(q_take);
    end
  end

endmodule
`default_nettype wire

@@ hdl/fbce_back.sv @@
// ----------------------------------------------------------------------------
// fbce_back
// Executes queued instructions on the architectural state; registered result.
// ----------------------------------------------------------------------------
`default_nettype none
module fbce_back
  import fbce_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  fbce_instr_t      q_data,
  output logic             q_take,
  output logic             empty,
  input  wire logic        pop,
  output logic [11:0]      next_pc,
  output logic [3:0]       acc_value,
  output logic             carry_flag,
  output logic [3:0]       mem_op,
  output logic [3:0]       mem_chip,
  output logic [7:0]       mem_addr,
  output logic [3:0]       write_data,
  output logic [2:0]       error_code
);

  localparam int LW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [11:0] pc_stack [STACK_DEPTH];
  logic [LW-1:0] stack_level;
  logic [3:0]  index_regs [INDEX_REG_COUNT];
  logic [3:0]  accumulator;
  logic        carry_bit;
  logic [3:0]  rom_select;
  logic [1:0]  ram_chip_select, ram_reg_select;
  logic [3:0]  ram_char_select;
  logic        out_valid;

  // next-state values
  logic [11:0] pc, page, top;
  logic [3:0]  acc, r_opa, r_p0, r_p1, r_inc, w_val0, w_val1;
  logic        cy, jump, wr0, wr1;
  logic [3:0]  wr_idx0;
  logic [3:0]  op, chip, wdata;
  logic [7:0]  addr;
  logic [2:0]  err;
  logic [LW-1:0] lvl;
  logic        push_stk;
  logic        set_src;
  logic [4:0]  sum;
  logic [3:0]  opa;
  logic [3:0]  pair;

  assign opa   = q_data.opa;
  assign pair  = {opa[3:1], 1'b0};
  assign top   = pc_stack[stack_level];
  assign r_opa = index_regs[opa];
  assign r_p0  = index_regs[pair];
  assign r_p1  = index_regs[pair | 4'd1];
  assign r_inc = r_opa + 4'd1;
  assign empty = !out_valid;
  assign q_take = q_valid && (!out_valid || pop);

  always_comb begin
    pc   = top + (q_data.two ? 12'd2 : 12'd1);
    page = {pc[11:8], 8'h00};
    acc  = accumulator;
    cy   = carry_bit;
    op   = MEM_NONE; chip = 4'd0; addr = 8'd0; wdata = 4'd0;
    err  = q_data.invalid ? ERR_INVALID : ERR_NONE;
    lvl  = stack_level;
    push_stk = 1'b0;
    wr0 = 1'b0; wr1 = 1'b0; wr_idx0 = opa; w_val0 = 4'd0; w_val1 = 4'd0;
    set_src = 1'b0;
    jump = 1'b0;
    sum  = 5'd0;
    case (q_data.opr)
      OPR_JCN: begin
        case (opa)
          4'd1:    jump = !q_data.test;
          4'd2:    jump = carry_bit;
          4'd4:    jump = (accumulator == 4'd0);
          4'd9:    jump = q_data.test;
          4'd10:   jump = !carry_bit;
          4'd12:   jump = (accumulator != 4'd0);
          default: jump = 1'b0;
        endcase
        if (jump) pc = page | {4'd0, q_data.b2};
      end
      OPR_FIM: begin
        if (!opa[0]) begin
          wr0 = 1'b1; wr1 = 1'b1; wr_idx0 = pair;
          w_val0 = q_data.b2[7:4]; w_val1 = q_data.b2[3:0];
        end else set_src = 1'b1;
      end
      OPR_FIN: begin
        if (!opa[0]) begin
          op = MEM_ROM_READ; chip = pc[11:8];
          addr = {index_regs[0], index_regs[1]};
          wr0 = 1'b1; wr1 = 1'b1; wr_idx0 = pair;
          w_val0 = q_data.rd[7:4]; w_val1 = q_data.rd[3:0];
        end else pc = page | {4'd0, r_p0, r_p1};
      end
      OPR_JUN: pc = {opa, q_data.b2};
      OPR_JMS: begin
        if (32'(stack_level) + 1 >= STACK_DEPTH) err = ERR_OVERFLOW;
        else begin
          push_stk = 1'b1;
          lvl = stack_level + LW'(1);
          pc = {opa, q_data.b2};
        end
      end
      OPR_INC: begin wr0 = 1'b1; w_val0 = r_inc; end
      OPR_ISZ: begin
        wr0 = 1'b1; w_val0 = r_inc;
        if (r_inc != 4'd0) pc = page | {4'd0, q_data.b2};
      end
      OPR_ADD: begin
        sum = {1'b0, accumulator} + {1'b0, r_opa} + {4'd0, carry_bit};
        acc = sum[3:0]; cy = sum[4];
      end
      OPR_SUB: begin
        sum = {1'b0, accumulator} + {1'b0, ~r_opa} + {4'd0, ~carry_bit};
        acc = sum[3:0]; cy = sum[4];
      end
      OPR_LD:  acc = r_opa;
      OPR_XCH: begin wr0 = 1'b1; w_val0 = accumulator; acc = r_opa; end
      OPR_BBL: begin
        if (stack_level == LW'(0)) err = ERR_UNDERFLOW;
        else begin
          lvl = stack_level - LW'(1);
          pc  = pc_stack[lvl];
          acc = opa;
        end
      end
      OPR_LDM: acc = opa;
      OPR_IO: begin
        chip = {2'b00, ram_chip_select};
        case (opa)
          4'd0: begin op = MEM_CHAR_WRITE; addr = {2'b00, ram_reg_select, ram_char_select};
                  wdata = accumulator; end
          4'd1: begin op = MEM_RAM_OUT; wdata = accumulator; end
          4'd2: begin op = MEM_ROM_OUT; chip = rom_select; wdata = accumulator; end
          4'd3: begin err = ERR_UNSUPP; chip = 4'd0; end
          4'd4, 4'd5, 4'd6, 4'd7: begin
            op = MEM_STAT_WRITE; addr = {2'b00, ram_reg_select, 2'b00, opa[1:0]};
            wdata = accumulator;
          end
          4'd8: begin
            op = MEM_CHAR_READ; addr = {2'b00, ram_reg_select, ram_char_select};
            sum = {1'b0, accumulator} + {1'b0, ~q_data.rd[3:0]} + {4'd0, ~carry_bit};
            acc = sum[3:0]; cy = sum[4];
          end
          4'd9: begin
            op = MEM_CHAR_READ; addr = {2'b00, ram_reg_select, ram_char_select};
            acc = q_data.rd[3:0];
          end
          4'd10: begin op = MEM_ROM_IN; chip = rom_select; acc = q_data.rd[3:0]; end
          4'd11: begin
            op = MEM_CHAR_READ; addr = {2'b00, ram_reg_select, ram_char_select};
            sum = {1'b0, accumulator} + {1'b0, q_data.rd[3:0]} + {4'd0, carry_bit};
            acc = sum[3:0]; cy = sum[4];
          end
          default: begin
            op = MEM_STAT_READ; addr = {2'b00, ram_reg_select, 2'b00, opa[1:0]};
            acc = q_data.rd[3:0];
          end
        endcase
      end
      OPR_ACC: begin
        case (opa)
          4'd0: begin acc = 4'd0; cy = 1'b0; end
          4'd1: cy = 1'b0;
          4'd2: begin sum = {1'b0, accumulator} + 5'd1; acc = sum[3:0]; cy = sum[4]; end
          4'd3: cy = ~carry_bit;
          4'd4: acc = ~accumulator;
          4'd5: begin acc = {accumulator[2:0], carry_bit}; cy = accumulator[3]; end
          4'd6: begin acc = {carry_bit, accumulator[3:1]}; cy = accumulator[0]; end
          4'd7: begin acc = {3'd0, carry_bit}; cy = 1'b0; end
          4'd8: begin sum = {1'b0, accumulator} + 5'd15; acc = sum[3:0]; cy = sum[4]; end
          4'd9: begin acc = carry_bit ? 4'd10 : 4'd9; cy = 1'b0; end
          4'd10: cy = 1'b1;
          4'd11: begin
            if (carry_bit || accumulator > 4'd9) begin
              sum = {1'b0, accumulator} + 5'd6;
              acc = sum[3:0];
              if (sum[4]) cy = 1'b1;
            end
          end
          4'd12: begin
            case (accumulator)
              4'd0: acc = 4'd0;
              4'd1: acc = 4'd1;
              4'd2: acc = 4'd2;
              4'd4: acc = 4'd3;
              4'd8: acc = 4'd4;
              default: acc = 4'd15;
            endcase
          end
          4'd13: err = ERR_UNSUPP;
          default: err = ERR_INVALID;
        endcase
      end
      default: ;
    endcase
    // errors change nothing
    if (err != ERR_NONE) begin
      pc = top; acc = accumulator; cy = carry_bit;
      op = MEM_NONE; chip = 4'd0; addr = 8'd0; wdata = 4'd0;
      lvl = stack_level; push_stk = 1'b0; wr0 = 1'b0; wr1 = 1'b0; set_src = 1'b0;
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STACK_DEPTH; i++) pc_stack[i] <= 12'd0;
      for (int i = 0; i < INDEX_REG_COUNT; i++) index_regs[i] <= 4'd0;
      stack_level <= '0;
      accumulator <= 4'd0;
      carry_bit <= 1'b0;
      rom_select <= 4'd0;
      ram_chip_select <= 2'd0;
      ram_reg_select <= 2'd0;
      ram_char_select <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_take) begin
        // return address is the PC past the two-byte call
        if (push_stk) pc_stack[stack_level] <= top + 12'd2;
        pc_stack[lvl] <= pc;
        stack_level <= lvl;
        accumulator <= acc;
        carry_bit <= cy;
        if (wr0) index_regs[wr_idx0] <= w_val0;
        if (wr1) index_regs[wr_idx0 | 4'd1] <= w_val1;
        if (set_src) begin
          rom_select <= r_p0;
          ram_chip_select <= r_p0[3:2];
          ram_reg_select <= r_p0[1:0];
          ram_char_select <= r_p1;
        end
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_take) begin
      next_pc <= pc; acc_value <= acc; carry_flag <= cy;
      mem_op <= op; mem_chip <= chip; mem_addr <= addr;
      write_data <= wdata; error_code <= err;
    end
  end

endmodule
`default_nettype wire

@@ hdl/fbce_checker.sv @@
// ----------------------------------------------------------------------------
// fbce_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module fbce_checker
  import fbce_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [3:0]  mem_op,
  input wire logic [3:0]  mem_chip,
  input wire logic [3:0]  write_data,
  input wire logic [2:0]  error_code,
  input wire logic [11:0] next_pc
);

  // an error result carries no request
  a_err_no_req: assert property (@(posedge clk) disable iff (rst)
    (!empty && error_code != ERR_NONE) |-> (mem_op == MEM_NONE && mem_chip == 4'd0))
    else $error("error result with memory request");

  // no request means no write data
  a_none_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && mem_op == MEM_NONE) |-> (write_data == 4'd0))
    else $error("write data without request");

  // an unpopped result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(next_pc) && $stable(error_code)))
    else $error("result changed while stalled");

  // reset leaves both sides idle
  a_reset: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("not idle after reset");

endmodule

bind four_bit_cpu_execute_unit fbce_checker u_fbce_checker (
  .clk, .rst, .full, .empty, .pop, .mem_op, .mem_chip, .write_data,
  .error_code, .next_pc
);
`default_nettype wire

@@ tb/cpu_exec_checker.sv @@
// ----------------------------------------------------------------------------
// cpu_exec_checker
// Watches the instruction and result channels of the execute unit, models the
// processor state for each accepted request and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none
module cpu_exec_checker
  import fbce_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [7:0]  instr_byte1,
  input  wire logic [7:0]  instr_byte2,
  input  wire logic        test_level,
  input  wire logic [7:0]  read_data,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [11:0] next_pc,
  input  wire logic [3:0]  acc_value,
  input  wire logic        carry_flag,
  input  wire logic [3:0]  mem_op,
  input  wire logic [3:0]  mem_chip,
  input  wire logic [7:0]  mem_addr,
  input  wire logic [3:0]  write_data,
  input  wire logic [2:0]  error_code,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] pc;
    logic [3:0]  acc;
    logic        cy;
    logic [3:0]  op;
    logic [3:0]  chip;
    logic [7:0]  addr;
    logic [3:0]  wdata;
    logic [2:0]  err;
  } exec_result_t;

  // architectural state mirror
  logic [11:0] pc_stack [STACK_DEPTH];
  int          level;
  logic [3:0]  regs [16];
  logic [3:0]  acc_q;
  logic        cy_q;
  logic [3:0]  rom_sel;
  logic [1:0]  chip_sel;
  logic [1:0]  reg_sel;
  logic [3:0]  char_sel;

  exec_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic logic [4:0] nib_add(logic [3:0] a, logic [3:0] b, logic c);
    return {1'b0, a} + {1'b0, b} + 5'(c);
  endfunction

  // executes one instruction on the mirror and returns its result
  function automatic exec_result_t execute(logic [7:0] b1, logic [7:0] b2, logic tst,
                                           logic [7:0] rd);
    exec_result_t r;
    logic [3:0] opr, opa, acc, t;
    logic [11:0] pc, page;
    logic [7:0] ram_a, stat_a;
    logic cy, two, jump;
    logic [4:0] s;
    int lvl, pr;
    opr = b1[7:4];
    opa = b1[3:0];
    pr = int'({opa[3:1], 1'b0});
    lvl = level;
    acc = acc_q;
    cy = cy_q;
    r = '0;
    jump = 1'b0;
    two = opr == OPR_JCN || opr == OPR_JUN || opr == OPR_JMS || opr == OPR_ISZ ||
          (opr == OPR_FIM && !opa[0]);
    pc = pc_stack[lvl] + (two ? 12'd2 : 12'd1);
    page = pc & 12'hf00;
    ram_a = {2'b00, reg_sel, char_sel};
    stat_a = {2'b00, reg_sel, 2'b00, opa[1:0]};
    case (opr)
      OPR_NOP: if (opa != 4'd0) r.err = ERR_INVALID;
      OPR_JCN: begin
        case (opa)
          4'd1:  jump = !tst;
          4'd2:  jump = cy;
          4'd4:  jump = acc == 4'd0;
          4'd9:  jump = tst;
          4'd10: jump = !cy;
          4'd12: jump = acc != 4'd0;
          default: r.err = ERR_INVALID;
        endcase
        if (r.err == ERR_NONE && jump) pc = page | {4'd0, b2};
      end
      OPR_FIM: begin
        if (!opa[0]) begin
          regs[pr] = b2[7:4];
          regs[pr+1] = b2[3:0];
        end else begin
          t = regs[pr];
          rom_sel = t;
          chip_sel = t[3:2];
          reg_sel = t[1:0];
          char_sel = regs[pr+1];
        end
      end
      OPR_FIN: begin
        if (!opa[0]) begin
          r.op = MEM_ROM_READ;
          r.chip = page[11:8];
          r.addr = {regs[0], regs[1]};
          regs[pr] = rd[7:4];
          regs[pr+1] = rd[3:0];
        end else begin
          pc = page | {4'd0, regs[pr], regs[pr+1]};
        end
      end
      OPR_JUN: pc = {opa, b2};
      OPR_JMS: begin
        if (lvl + 1 >= STACK_DEPTH) r.err = ERR_OVERFLOW;
        else begin
          pc_stack[lvl] = pc;
          lvl++;
          pc = {opa, b2};
        end
      end
      OPR_INC: regs[opa] = regs[opa] + 4'd1;
      OPR_ISZ: begin
        regs[opa] = regs[opa] + 4'd1;
        if (regs[opa] != 4'd0) pc = page | {4'd0, b2};
      end
      OPR_ADD: begin
        s = nib_add(acc, regs[opa], cy);
        {cy, acc} = s;
      end
      OPR_SUB: begin
        s = nib_add(acc, ~regs[opa], !cy);
        {cy, acc} = s;
      end
      OPR_LD: acc = regs[opa];
      OPR_XCH: begin
        t = regs[opa];
        regs[opa] = acc;
        acc = t;
      end
      OPR_BBL: begin
        if (lvl == 0) r.err = ERR_UNDERFLOW;
        else begin
          lvl--;
          pc = pc_stack[lvl];
          acc = opa;
        end
      end
      OPR_LDM: acc = opa;
      OPR_IO: begin
        case (opa)
          4'd0: begin
            r.op = MEM_CHAR_WRITE; r.chip = {2'b00, chip_sel}; r.addr = ram_a;
            r.wdata = acc;
          end
          4'd1: begin r.op = MEM_RAM_OUT; r.chip = {2'b00, chip_sel}; r.wdata = acc; end
          4'd2: begin r.op = MEM_ROM_OUT; r.chip = rom_sel; r.wdata = acc; end
          4'd3: r.err = ERR_UNSUPP;
          4'd4, 4'd5, 4'd6, 4'd7: begin
            r.op = MEM_STAT_WRITE; r.chip = {2'b00, chip_sel}; r.addr = stat_a;
            r.wdata = acc;
          end
          4'd8: begin
            r.op = MEM_CHAR_READ; r.chip = {2'b00, chip_sel}; r.addr = ram_a;
            s = nib_add(acc, ~rd[3:0], !cy);
            {cy, acc} = s;
          end
          4'd9: begin
            r.op = MEM_CHAR_READ; r.chip = {2'b00, chip_sel}; r.addr = ram_a;
            acc = rd[3:0];
          end
          4'd10: begin r.op = MEM_ROM_IN; r.chip = rom_sel; acc = rd[3:0]; end
          4'd11: begin
            r.op = MEM_CHAR_READ; r.chip = {2'b00, chip_sel}; r.addr = ram_a;
            s = nib_add(acc, rd[3:0], cy);
            {cy, acc} = s;
          end
          default: begin
            r.op = MEM_STAT_READ; r.chip = {2'b00, chip_sel}; r.addr = stat_a;
            acc = rd[3:0];
          end
        endcase
      end
      default: begin
        case (opa)
          4'd0: begin acc = 4'd0; cy = 1'b0; end
          4'd1: cy = 1'b0;
          4'd2: begin s = nib_add(acc, 4'd1, 1'b0); {cy, acc} = s; end
          4'd3: cy = !cy;
          4'd4: acc = ~acc;
          4'd5: begin t = {3'b0, acc[3]}; acc = {acc[2:0], cy}; cy = t[0]; end
          4'd6: begin t = {3'b0, acc[0]}; acc = {cy, acc[3:1]}; cy = t[0]; end
          4'd7: begin acc = {3'b0, cy}; cy = 1'b0; end
          4'd8: begin s = nib_add(acc, 4'd15, 1'b0); {cy, acc} = s; end
          4'd9: begin acc = cy ? 4'd10 : 4'd9; cy = 1'b0; end
          4'd10: cy = 1'b1;
          4'd11: begin
            if (cy || acc > 4'd9) begin
              s = nib_add(acc, 4'd6, 1'b0);
              acc = s[3:0];
              if (s[4]) cy = 1'b1;
            end
          end
          4'd12: begin
            case (acc)
              4'd0: acc = 4'd0;
              4'd1: acc = 4'd1;
              4'd2: acc = 4'd2;
              4'd4: acc = 4'd3;
              4'd8: acc = 4'd4;
              default: acc = 4'd15;
            endcase
          end
          4'd13: r.err = ERR_UNSUPP;
          default: r.err = ERR_INVALID;
        endcase
      end
    endcase
    // errors leave the state untouched; the register writes above only
    // happen on paths that cannot fail
    if (r.err != ERR_NONE) begin
      r.pc = pc_stack[level];
      r.acc = acc_q;
      r.cy = cy_q;
      r.op = MEM_NONE; r.chip = '0; r.addr = '0; r.wdata = '0;
      return r;
    end
    level = lvl;
    pc_stack[lvl] = pc;
    acc_q = acc;
    cy_q = cy;
    r.pc = pc;
    r.acc = acc;
    r.cy = cy;
    return r;
  endfunction

  // predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    exec_result_t e;
    if (rst) begin
      for (int i = 0; i < STACK_DEPTH; i++) pc_stack[i] = '0;
      for (int i = 0; i < 16; i++) regs[i] = '0;
      level = 0; acc_q = '0; cy_q = 1'b0;
      rom_sel = '0; chip_sel = '0; reg_sel = '0; char_sel = '0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (next_pc !== e.pc) begin
            $error("next_pc exp %0h got %0h", e.pc, next_pc); fail_count++;
          end
          if (acc_value !== e.acc) begin
            $error("acc_value exp %0h got %0h", e.acc, acc_value); fail_count++;
          end
          if (carry_flag !== e.cy) begin
            $error("carry_flag exp %0b got %0b", e.cy, carry_flag); fail_count++;
          end
          if (mem_op !== e.op) begin
            $error("mem_op exp %0d got %0d", e.op, mem_op); fail_count++;
          end
          if (mem_chip !== e.chip) begin
            $error("mem_chip exp %0h got %0h", e.chip, mem_chip); fail_count++;
          end
          if (mem_addr !== e.addr) begin
            $error("mem_addr exp %0h got %0h", e.addr, mem_addr); fail_count++;
          end
          if (write_data !== e.wdata) begin
            $error("write_data exp %0h got %0h", e.wdata, write_data); fail_count++;
          end
          if (error_code !== e.err) begin
            $error("error_code exp %0d got %0d", e.err, error_code); fail_count++;
          end
        end
      end
      if (push && !full)
        expected_results.push_back(execute(instr_byte1, instr_byte2, test_level, read_data));
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives instruction requests into the 4-bit CPU execute unit with random
// gaps and result stalls; a checker alongside predicts and compares results.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fbce_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  instr_byte1 = '0;
  logic [7:0]  instr_byte2 = '0;
  logic        test_level = 1'b0;
  logic [7:0]  read_data = '0;
  logic        pop = 1'b0;
  logic        full, empty, carry_flag;
  logic [11:0] next_pc;
  logic [3:0]  acc_value, mem_op, mem_chip, write_data;
  logic [7:0]  mem_addr;
  logic [2:0]  error_code;
  int          fail_count, pending;
  int          pop_wait = 0;
  bit          stim_done = 0;
  bit          no_stall = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_bit_cpu_execute_unit i_dut (.*);

  cpu_exec_checker i_chk (.*);

  // send one instruction request, with a random gap ahead of it
  task automatic send_instr(logic [7:0] b1, logic [7:0] b2);
    int gap;
    gap = no_stall ? 0 : $urandom_range(5);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    instr_byte1 <= b1;
    instr_byte2 <= b2;
    test_level <= 1'($urandom);
    read_data <= 8'($urandom);
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // mostly valid code, weighted toward calls/returns and register traffic
  function automatic logic [7:0] pick_opcode();
    int k;
    k = $urandom_range(99);
    if (k < 8) return {OPR_JMS, 4'($urandom)};
    if (k < 16) return {OPR_BBL, 4'($urandom)};
    if (k < 22) return {OPR_FIM, 4'($urandom)};
    if (k < 26) return {OPR_JCN, 4'($urandom)};
    return 8'($urandom);
  endfunction

  // result side: a random wait before popping is drawn per result
  always @(posedge clk) begin
    int w;
    if (rst) begin
      pop <= 1'b0;
      pop_wait <= 0;
    end else if (no_stall) begin
      pop <= 1'b1;
      pop_wait <= 0;
    end else if (pop && !empty) begin
      w = $urandom_range(5);
      pop_wait <= w;
      pop <= (w == 0);
    end else if (pop_wait > 0) begin
      pop_wait <= pop_wait - 1;
      pop <= (pop_wait == 1);
    end else begin
      pop <= 1'b1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: a subset of opcode nibbles, error cases, stack limits, extremes
    send_instr(8'hC0, 8'h00);   // return with empty stack
    for (int i = 0; i < 4; i++) send_instr({OPR_JMS, 4'hF}, 8'hFF);  // last overflows
    send_instr(8'h2F, 8'hFF);
    send_instr(8'h20, 8'hFF);
    send_instr(8'h21, 8'h00);
    send_instr(8'hE0, 8'h00);
    send_instr(8'hEC, 8'h00);
    send_instr(8'hE3, 8'h00);   // WPM unsupported
    send_instr(8'hFD, 8'h00);   // DCL unsupported
    send_instr(8'hFE, 8'h00);
    send_instr(8'hFF, 8'h00);
    send_instr(8'h01, 8'h00);
    send_instr(8'h13, 8'h00);   // bad jump condition
    send_instr(8'h14, 8'hAB);
    send_instr(8'h30, 8'h00);
    send_instr(8'h31, 8'h00);
    send_instr(8'h7F, 8'h00);
    send_instr(8'h9F, 8'h00);
    send_instr(8'hFB, 8'h00);
    for (int i = 0; i < 4; i++) send_instr({OPR_BBL, 4'(i)}, 8'h00);
    // random body, with a stretch of full-rate traffic
    for (int n = 0; n < 1400; n++) begin
      no_stall = (n >= 600 && n < 750);
      send_instr(pick_opcode(), 8'($urandom));
    end
    no_stall = 0;
    push <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
